// ----- sv/gbba_pkg.sv -----
// Shared types, codes and helpers of the grouped bitmap block allocator.
// No dependencies; the top level, the checkers and the testbench import this package.
`default_nettype none

package gbba_pkg;

    // Default geometry; the top level takes these as parameter defaults.
    localparam int BITS_PER_GROUP_DEF = 1024;
    localparam int GROUPS_DEF         = 16;

    // Fixed field widths.
    localparam int TB_W     = 15;
    localparam int FREE_W   = 11;
    localparam int WORD_W   = 32;
    localparam int CFG_IX_W = 1;

    localparam logic [TB_W-1:0] VOL_BLOCKS_RST = 15'd16384;

    // Configuration register indexes.
    localparam logic [CFG_IX_W-1:0] CFG_VOL_BLOCKS       = 1'd0;
    localparam logic [CFG_IX_W-1:0] CFG_FIRST_DATA_BLOCK = 1'd1;

    // Request modes.
    localparam logic [1:0] MODE_ALLOC      = 2'd0;
    localparam logic [1:0] MODE_LOAD_WORD  = 2'd1;
    localparam logic [1:0] MODE_LOAD_COUNT = 2'd2;

    // Response status codes.
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NO_GROUP    = 2'd1;
    localparam logic [1:0] ST_BITMAP_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]        mode;
        logic [3:0]        start_group;
        logic [3:0]        load_group;
        logic [4:0]        word_index;
        logic [WORD_W-1:0] word_value;
        logic [FREE_W-1:0] free_value;
    } req_t;

    typedef struct packed {
        logic [TB_W-1:0] block_number;
        logic [1:0]      status;
    } rsp_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_SCAN,
        S_MARK,
        S_LOAD,
        S_REPLY
    } state_t;

    // Position of the lowest clear bit; the word must hold at least one.
    function automatic logic [4:0] first_zero(input logic [WORD_W-1:0] word);
        logic [WORD_W-1:0] w;
        logic [4:0]        pos;
        w   = word;
        pos = '0;
        if (w[15:0] == 16'hFFFF) begin
            pos[4] = 1'b1;
            w      = w >> 16;
        end
        if (w[7:0] == 8'hFF) begin
            pos[3] = 1'b1;
            w      = w >> 8;
        end
        if (w[3:0] == 4'hF) begin
            pos[2] = 1'b1;
            w      = w >> 4;
        end
        if (w[1:0] == 2'h3) begin
            pos[1] = 1'b1;
            w      = w >> 2;
        end
        if (w[0]) begin
            pos[0] = 1'b1;
        end
        return pos;
    endfunction

endpackage

`default_nettype wire

// ----- sv/gbba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module gbba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- sv/grouped_bitmap_block_allocator.sv -----
// Top level of the grouped bitmap block allocator: sequencer, configuration
// registers and output register. Depends on gbba_pkg and gbba_ram.
`default_nettype none

// The volume is split into GROUPS groups of BITS_PER_GROUP blocks, each with
// a bitmap held as 32-bit words in one RAM and a free counter held in a
// second RAM. An allocate request walks the group counters round robin from
// start_group, one counter read per cycle, takes the first group with a
// nonzero counter, then scans that group's bitmap words one read per cycle
// for the first word that is not full, sets its lowest clear bit, decrements
// the counter and returns the block number. The counter walk and the word
// scan share one issue/check pipeline against the registered-read RAM ports,
// and that read port sets the pace. After reset the block runs a clearing
// pass that zeroes the bitmap and fills the counters; s_ready stays low
// until it ends, while configuration writes are taken at any time. One
// request is in flight at a time; a finished response sits in the output
// register, so the next request is accepted while it waits for m_ready.
module grouped_bitmap_block_allocator #(
    parameter int BITS_PER_GROUP = gbba_pkg::BITS_PER_GROUP_DEF,
    parameter int GROUPS         = gbba_pkg::GROUPS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // request channel
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire gbba_pkg::req_t                s_payload,
    // response channel
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output gbba_pkg::rsp_t                     m_payload,
    // configuration write port
    input  wire logic                          cfg_wr_en,
    input  wire logic [gbba_pkg::CFG_IX_W-1:0] cfg_index,
    input  wire logic [gbba_pkg::TB_W-1:0]     cfg_wdata
);

    import gbba_pkg::*;

    // Geometry derived from the parameters.
    localparam int WPG         = BITS_PER_GROUP / WORD_W;
    localparam int TOTAL_WORDS = GROUPS * WPG;
    localparam int BM_AW       = (TOTAL_WORDS > 1) ? $clog2(TOTAL_WORDS) : 1;
    localparam int CNT_AW      = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int CNT_W       = ($clog2(BITS_PER_GROUP + 1) > FREE_W) ?
                                 $clog2(BITS_PER_GROUP + 1) : FREE_W;
    localparam int GW          = (CNT_AW > 4) ? CNT_AW : 4;
    localparam int WIW         = (WPG > 1) ? $clog2(WPG) : 1;
    localparam int IDX_W       = (GW > WIW) ? GW : WIW;
    localparam int NB_W        = GW + 17;

    // Control state
    state_t              state_reg, state_next;
    logic [BM_AW-1:0]    clr_reg, clr_next;
    logic [IDX_W-1:0]    iss_idx_reg, iss_idx_next;
    logic [CNT_AW-1:0]   iss_cnt_reg, iss_cnt_next;
    logic                iss_on_reg, iss_on_next;
    logic                chk_v_reg, chk_v_next;
    logic                m_valid_reg, m_valid_next;
    logic [TB_W-1:0]     vol_blocks_reg;
    logic                first_data_block_reg;

    // Payload state
    req_t                req_reg, req_next;
    logic [IDX_W-1:0]    chk_idx_reg, chk_idx_next;
    logic                chk_last_reg, chk_last_next;
    logic                chk_in_reg, chk_in_next;
    logic [GW-1:0]       grp_reg, grp_next;
    logic [CNT_W-1:0]    cnt_val_reg, cnt_val_next;
    logic [BM_AW-1:0]    word_base_reg, word_base_next;
    logic [BM_AW-1:0]    mark_addr_reg, mark_addr_next;
    logic [WIW-1:0]      mark_w_reg, mark_w_next;
    logic [WORD_W-1:0]   word_reg, word_next;
    rsp_t                rsp_reg, rsp_next;
    rsp_t                m_payload_reg, m_payload_next;

    // RAM ports
    logic                bm_we;
    logic [BM_AW-1:0]    bm_waddr, bm_raddr;
    logic [WORD_W-1:0]   bm_wdata, bm_rdata;
    logic                cnt_we;
    logic [CNT_AW-1:0]   cnt_waddr, cnt_raddr;
    logic [CNT_W-1:0]    cnt_wdata, cnt_rdata;

    // Walk and scan helpers
    logic [GW-1:0]       iss_grp;
    logic [GW-1:0]       nxt_grp;
    logic                grp_last;
    logic                word_last;
    logic [4:0]          bit_pos;
    logic [NB_W-1:0]     block_calc;

    gbba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TOTAL_WORDS),
        .AW    (BM_AW)
    ) u_bitmap_ram (
        .aclk  (aclk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    gbba_ram #(
        .WIDTH (CNT_W),
        .DEPTH (GROUPS),
        .AW    (CNT_AW)
    ) u_count_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    // Next group of the walk: wrap to zero past the last group or once the
    // group base reaches the volume size.
    function automatic logic [GW-1:0] next_grp(input logic [GW-1:0] g,
                                                input logic [TB_W-1:0] tb);
        logic [GW:0]     n;
        logic [NB_W-1:0] nbase;
        n     = {1'b0, g} + 1'b1;
        nbase = NB_W'(n) * NB_W'(BITS_PER_GROUP);
        if ((32'(n) >= GROUPS) || (nbase >= NB_W'(tb))) begin
            return '0;
        end
        return GW'(n);
    endfunction

    assign iss_grp   = iss_idx_reg[GW-1:0];
    assign nxt_grp   = next_grp(iss_grp, vol_blocks_reg);
    // The walk ends when it is back at the start or has seen GROUPS groups.
    assign grp_last  = (nxt_grp == GW'(req_reg.start_group)) ||
                       (iss_cnt_reg == CNT_AW'(GROUPS - 1));
    assign word_last = (iss_idx_reg[WIW-1:0] == WIW'(WPG - 1));
    assign bit_pos   = first_zero(word_reg);
    assign block_calc = NB_W'(grp_reg) * NB_W'(BITS_PER_GROUP)
                      + (NB_W'(mark_w_reg) << 5)
                      + NB_W'(bit_pos)
                      + NB_W'(first_data_block_reg);

    // Read addresses follow the issue pointer; the shared check stage sees
    // the data in the cycle after.
    assign cnt_raddr = iss_grp[CNT_AW-1:0];
    assign bm_raddr  = word_base_reg + BM_AW'(iss_idx_reg[WIW-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg            <= S_CLEAR;
            clr_reg              <= '0;
            iss_idx_reg          <= '0;
            iss_cnt_reg          <= '0;
            iss_on_reg           <= 1'b0;
            chk_v_reg            <= 1'b0;
            m_valid_reg          <= 1'b0;
            vol_blocks_reg       <= VOL_BLOCKS_RST;
            first_data_block_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            iss_idx_reg <= iss_idx_next;
            iss_cnt_reg <= iss_cnt_next;
            iss_on_reg  <= iss_on_next;
            chk_v_reg   <= chk_v_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_VOL_BLOCKS:       vol_blocks_reg       <= cfg_wdata;
                    CFG_FIRST_DATA_BLOCK: first_data_block_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        chk_idx_reg   <= chk_idx_next;
        chk_last_reg  <= chk_last_next;
        chk_in_reg    <= chk_in_next;
        grp_reg       <= grp_next;
        cnt_val_reg   <= cnt_val_next;
        word_base_reg <= word_base_next;
        mark_addr_reg <= mark_addr_next;
        mark_w_reg    <= mark_w_next;
        word_reg      <= word_next;
        rsp_reg       <= rsp_next;
        m_payload_reg <= m_payload_next;
    end

    always_comb begin
        // hold by default
        state_next     = state_reg;
        clr_next       = clr_reg;
        iss_idx_next   = iss_idx_reg;
        iss_cnt_next   = iss_cnt_reg;
        iss_on_next    = iss_on_reg;
        chk_v_next     = 1'b0;
        chk_idx_next   = chk_idx_reg;
        chk_last_next  = chk_last_reg;
        chk_in_next    = chk_in_reg;
        req_next       = req_reg;
        grp_next       = grp_reg;
        cnt_val_next   = cnt_val_reg;
        word_base_next = word_base_reg;
        mark_addr_next = mark_addr_reg;
        mark_w_next    = mark_w_reg;
        word_next      = word_reg;
        rsp_next       = rsp_reg;
        m_payload_next = m_payload_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        s_ready        = 1'b0;

        bm_we     = 1'b0;
        bm_waddr  = mark_addr_reg;
        bm_wdata  = word_reg | (WORD_W'(1) << bit_pos);
        cnt_we    = 1'b0;
        cnt_waddr = grp_reg[CNT_AW-1:0];
        cnt_wdata = cnt_val_reg - 1'b1;

        case (state_reg)
            S_CLEAR: begin
                // zero one bitmap word per cycle, fill the counters on the way
                bm_we     = 1'b1;
                bm_waddr  = clr_reg;
                bm_wdata  = '0;
                cnt_we    = (32'(clr_reg) < GROUPS);
                cnt_waddr = clr_reg[CNT_AW-1:0];
                cnt_wdata = CNT_W'(BITS_PER_GROUP);
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == BM_AW'(TOTAL_WORDS - 1)) begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    req_next = s_payload;
                    case (s_payload.mode)
                        MODE_ALLOC: begin
                            iss_idx_next = IDX_W'(s_payload.start_group);
                            iss_cnt_next = '0;
                            iss_on_next  = 1'b1;
                            state_next   = S_WALK;
                        end
                        MODE_LOAD_WORD, MODE_LOAD_COUNT: begin
                            state_next = S_LOAD;
                        end
                        default: begin
                            rsp_next   = '{block_number: '0, status: ST_OK};
                            state_next = S_REPLY;
                        end
                    endcase
                end
            end

            S_WALK: begin
                // issue one counter read per cycle
                if (iss_on_reg) begin
                    iss_idx_next  = IDX_W'(nxt_grp);
                    iss_cnt_next  = iss_cnt_reg + 1'b1;
                    iss_on_next   = !grp_last;
                    chk_v_next    = 1'b1;
                    chk_idx_next  = iss_idx_reg;
                    chk_last_next = grp_last;
                    // a start group past the last group counts as empty
                    chk_in_next   = (32'(iss_grp) < GROUPS);
                end
                // check the counter that came back
                if (chk_v_reg) begin
                    if (chk_in_reg && (cnt_rdata != '0)) begin
                        grp_next       = chk_idx_reg[GW-1:0];
                        cnt_val_next   = cnt_rdata;
                        word_base_next = BM_AW'(32'(chk_idx_reg[GW-1:0]) * WPG);
                        iss_idx_next   = '0;
                        iss_on_next    = 1'b1;
                        chk_v_next     = 1'b0;
                        state_next     = S_SCAN;
                    end else if (chk_last_reg) begin
                        iss_on_next = 1'b0;
                        chk_v_next  = 1'b0;
                        rsp_next    = '{block_number: '0, status: ST_NO_GROUP};
                        state_next  = S_REPLY;
                    end
                end
            end

            S_SCAN: begin
                // issue one bitmap word read per cycle
                if (iss_on_reg) begin
                    iss_idx_next  = iss_idx_reg + 1'b1;
                    iss_on_next   = !word_last;
                    chk_v_next    = 1'b1;
                    chk_idx_next  = iss_idx_reg;
                    chk_last_next = word_last;
                end
                // the first word that is not full wins
                if (chk_v_reg) begin
                    if (bm_rdata != '1) begin
                        word_next      = bm_rdata;
                        mark_w_next    = chk_idx_reg[WIW-1:0];
                        mark_addr_next = word_base_reg + BM_AW'(chk_idx_reg[WIW-1:0]);
                        iss_on_next    = 1'b0;
                        chk_v_next     = 1'b0;
                        state_next     = S_MARK;
                    end else if (chk_last_reg) begin
                        // full bitmap: leave bitmap and counter untouched
                        iss_on_next = 1'b0;
                        chk_v_next  = 1'b0;
                        rsp_next    = '{block_number: '0, status: ST_BITMAP_FULL};
                        state_next  = S_REPLY;
                    end
                end
            end

            S_MARK: begin
                // set the bit, drop the counter, form the block number
                bm_we      = 1'b1;
                cnt_we     = 1'b1;
                rsp_next   = '{block_number: block_calc[TB_W-1:0], status: ST_OK};
                state_next = S_REPLY;
            end

            S_LOAD: begin
                bm_waddr  = BM_AW'(32'(req_reg.load_group) * WPG
                                   + 32'(req_reg.word_index));
                bm_wdata  = req_reg.word_value;
                cnt_waddr = CNT_AW'(req_reg.load_group);
                cnt_wdata = CNT_W'(req_reg.free_value);
                case (req_reg.mode)
                    MODE_LOAD_WORD: begin
                        bm_we = (32'(req_reg.load_group) < GROUPS) &&
                                (32'(req_reg.word_index) < WPG);
                    end
                    MODE_LOAD_COUNT: begin
                        cnt_we = (32'(req_reg.load_group) < GROUPS);
                    end
                    default: ;
                endcase
                rsp_next   = '{block_number: '0, status: ST_OK};
                state_next = S_REPLY;
            end

            S_REPLY: begin
                // advance once the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_payload_next = rsp_reg;
                    state_next     = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

`default_nettype wire

// ----- sv/gbba_check.sv -----
// Port-level checker for the grouped bitmap block allocator, bound to the
// top level below. Depends on gbba_pkg.
`default_nettype none

module gbba_check (
    input wire logic           aclk,
    input wire logic           aresetn,
    input wire logic           s_valid,
    input wire logic           s_ready,
    input wire logic           m_valid,
    input wire logic           m_ready,
    input wire gbba_pkg::rsp_t m_payload
);

    import gbba_pkg::*;

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("response dropped or changed while stalled");

    // one request at a time: no acceptance right after an acceptance
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while another is in flight");

    // failed allocations carry block number zero
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_payload.status != ST_OK) |-> m_payload.block_number == '0)
        else $error("nonzero block number on a failed allocation");

    // the clearing pass keeps requests out right after reset
    a_clear_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !s_ready && !m_valid)
        else $error("ready or response right after reset");

endmodule

bind grouped_bitmap_block_allocator gbba_check u_gbba_check (.*);

`default_nettype wire

// ----- bench/gbba_alloc_checker.sv -----
// Checker for the grouped bitmap block allocator: predicts every response
// from its own copy of the bitmap, counters and registers. Depends on gbba_pkg.
`timescale 1ns / 100ps

module gbba_alloc_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    input  wire logic                          s_ready,
    input  wire gbba_pkg::req_t                s_payload,
    input  wire logic                          m_valid,
    input  wire logic                          m_ready,
    input  wire gbba_pkg::rsp_t                m_payload,
    input  wire logic                          cfg_wr_en,
    input  wire logic [gbba_pkg::CFG_IX_W-1:0] cfg_index,
    input  wire logic [gbba_pkg::TB_W-1:0]     cfg_wdata,
    output int                                 fail_count,
    output int                                 outstanding
);
    import gbba_pkg::*;

    localparam int BPG  = BITS_PER_GROUP_DEF;
    localparam int NGRP = GROUPS_DEF;
    localparam int WPG  = BPG / 32;

    logic [WORD_W-1:0] used_map [0:NGRP*WPG-1];
    logic [FREE_W-1:0] free_left [0:NGRP-1];
    logic [TB_W-1:0]   vol_blocks;
    logic              data_offset;

    rsp_t pending_replies [$];
    int   errors = 0;

    initial begin
        fail_count  = 0;
        outstanding = 0;
    end

    // Apply one request to the shadow state and work out its response.
    task automatic allocate_or_load(input req_t r, output rsp_t e);
        int g;
        int nxt;
        int k;
        int w;
        int b;
        int num;
        logic found;
        logic done;
        logic hit;
        logic [WORD_W-1:0] word;
        e.block_number = '0;
        e.status       = ST_OK;
        case (r.mode)
            MODE_ALLOC: begin
                g     = int'(r.start_group);
                found = 1'b0;
                done  = 1'b0;
                for (k = 0; k < NGRP; k++) begin
                    if (!done) begin
                        if (g < NGRP && free_left[g] != '0) begin
                            found = 1'b1;
                            done  = 1'b1;
                        end else begin
                            nxt = g + 1;
                            if (nxt >= NGRP || nxt * BPG >= int'(vol_blocks)) nxt = 0;
                            g = nxt;
                            if (g == int'(r.start_group)) done = 1'b1;
                        end
                    end
                end
                if (!found) begin
                    e.status = ST_NO_GROUP;
                end else begin
                    hit = 1'b0;
                    for (w = 0; w < WPG; w++) begin
                        word = used_map[g*WPG + w];
                        for (b = 0; b < 32; b++) begin
                            if (!hit && !word[b]) begin
                                hit = 1'b1;
                                used_map[g*WPG + w] = word | (32'h1 << b);
                                free_left[g] = free_left[g] - 1'b1;
                                num = g * BPG + w * 32 + b + int'(data_offset);
                                e.block_number = num[TB_W-1:0];
                            end
                        end
                    end
                    if (!hit) e.status = ST_BITMAP_FULL;
                end
            end
            MODE_LOAD_WORD: begin
                if (int'(r.load_group) < NGRP && int'(r.word_index) < WPG)
                    used_map[int'(r.load_group)*WPG + int'(r.word_index)] = r.word_value;
            end
            MODE_LOAD_COUNT: begin
                if (int'(r.load_group) < NGRP) free_left[r.load_group] = r.free_value;
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge aclk) begin : watch
        rsp_t want;
        rsp_t pred;
        int   i;
        if (!aresetn) begin
            for (i = 0; i < NGRP*WPG; i++) used_map[i] = '0;
            for (i = 0; i < NGRP; i++) free_left[i] = FREE_W'(BPG);
            vol_blocks  = VOL_BLOCKS_RST;
            data_offset = 1'b0;
            pending_replies.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_VOL_BLOCKS:       vol_blocks  = cfg_wdata;
                    CFG_FIRST_DATA_BLOCK: data_offset = cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
            if (m_valid && m_ready) begin
                if (pending_replies.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected response: block_number %0d status %0d",
                                 m_payload.block_number, m_payload.status);
                end else begin
                    want = pending_replies.pop_front();
                    if (m_payload.block_number !== want.block_number ||
                        m_payload.status !== want.status) begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: block_number exp %0d got %0d, ",
                                      "status exp %0d got %0d"},
                                     want.block_number, m_payload.block_number,
                                     want.status, m_payload.status);
                    end
                end
            end
            if (s_valid && s_ready) begin
                allocate_or_load(s_payload, pred);
                pending_replies.push_back(pred);
            end
        end
        outstanding <= pending_replies.size();
        fail_count  <= errors;
    end

endmodule

// ----- bench/grouped_bitmap_block_allocator_tb.sv -----
// Top of the allocator testbench: clock, reset, request and response
// traffic, register settings and the verdict. Depends on gbba_pkg and gbba_alloc_checker.
`timescale 1ns / 100ps

module grouped_bitmap_block_allocator_tb;
    import gbba_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int HOLDOFF_LEN   = 400;
    localparam int PHASE_ITEMS   = 133;
    localparam int PHASES        = 7;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    req_t                s_payload = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    rsp_t                m_payload;
    logic                cfg_wr_en = 1'b0;
    logic [CFG_IX_W-1:0] cfg_index = '0;
    logic [TB_W-1:0]     cfg_wdata = '0;

    int fail_count;
    int outstanding;

    // Traffic shaping: percent of cycles each side sits idle.
    int src_idle_pct = 0;
    int dst_idle_pct = 0;
    int items_sent   = 0;
    int cycle_count  = 0;

    // Long receiver hold-off: toggle hold_req to start one.
    logic hold_req  = 1'b0;
    logic hold_ack  = 1'b0;
    int   hold_left = 0;

    always #5 aclk = ~aclk;

    grouped_bitmap_block_allocator uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    gbba_alloc_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_payload   (s_payload),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_payload   (m_payload),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Receiver: stall at random, or hold off for a long stretch on demand so
    // the output register fills and the block backs up into its input.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLDOFF_LEN;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= dst_idle_pct);
        end
    end

    // Watchdog: end the run with a failure once the cycle limit is reached.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Fully random request; callers overwrite the fields that matter.
    function automatic req_t rand_req();
        req_t r;
        r.mode        = 2'($urandom_range(0, 3));
        r.start_group = 4'($urandom_range(0, 15));
        r.load_group  = 4'($urandom_range(0, 15));
        r.word_index  = 5'($urandom_range(0, 31));
        r.word_value  = $urandom;
        r.free_value  = FREE_W'($urandom_range(0, 2047));
        return r;
    endfunction

    function automatic req_t alloc_req(input logic [3:0] start);
        req_t r;
        r             = rand_req();
        r.mode        = MODE_ALLOC;
        r.start_group = start;
        return r;
    endfunction

    function automatic req_t word_req(input logic [3:0] grp, input logic [4:0] idx,
                                      input logic [WORD_W-1:0] value);
        req_t r;
        r            = rand_req();
        r.mode       = MODE_LOAD_WORD;
        r.load_group = grp;
        r.word_index = idx;
        r.word_value = value;
        return r;
    endfunction

    function automatic req_t count_req(input logic [3:0] grp, input logic [FREE_W-1:0] value);
        req_t r;
        r            = rand_req();
        r.mode       = MODE_LOAD_COUNT;
        r.load_group = grp;
        r.free_value = value;
        return r;
    endfunction

    // Lean word loads toward full, empty and nearly full words.
    function automatic logic [WORD_W-1:0] biased_word();
        case ($urandom_range(0, 4))
            0:       return 32'hFFFF_FFFF;
            1:       return 32'h0;
            2:       return ~(32'h1 << $urandom_range(0, 31));
            3:       return 32'hFFFF_FFFF << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // Lean counter loads toward zero so walks cross empty groups.
    function automatic logic [FREE_W-1:0] biased_count();
        case ($urandom_range(0, 5))
            0, 1, 2: return '0;
            3:       return FREE_W'($urandom_range(1, 3));
            4:       return FREE_W'(BITS_PER_GROUP_DEF);
            default: return FREE_W'($urandom_range(0, 2047));
        endcase
    endfunction

    // Offer one request, idling first at the current rate; hold it until taken.
    task automatic send_req(input req_t r);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // Drop valid and wait until every response is back.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_config(input logic [TB_W-1:0] blocks, input logic offset);
        logic [TB_W-1:0] wd;
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_VOL_BLOCKS;
        cfg_wdata <= blocks;
        @(posedge aclk);
        // Upper bits of the offset write are don't-care; toggle them anyway.
        wd        = TB_W'($urandom);
        wd[0]     = offset;
        cfg_index <= CFG_FIRST_DATA_BLOCK;
        cfg_wdata <= wd;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic directed();
        req_t r;
        // Plain allocations at both ends of the group range.
        send_req(alloc_req(4'd0));
        send_req(alloc_req(4'd15));
        // Empty counter: the walk steps to the next group.
        send_req(count_req(4'd3, '0));
        send_req(alloc_req(4'd3));
        // Empty last group: the walk wraps to group zero.
        send_req(count_req(4'd15, '0));
        send_req(alloc_req(4'd15));
        // Counter stored above the group size, at the field maximum.
        send_req(count_req(4'd7, 11'h7FF));
        send_req(alloc_req(4'd7));
        // Full first word, then a word with only its top bit clear.
        send_req(word_req(4'd1, 5'd0, 32'hFFFF_FFFF));
        send_req(alloc_req(4'd1));
        send_req(word_req(4'd1, 5'd1, 32'h7FFF_FFFF));
        send_req(word_req(4'd1, 5'd2, 32'hFFFF_FFFF));
        send_req(alloc_req(4'd1));
        send_req(word_req(4'd2, 5'd31, 32'h0));
        send_req(count_req(4'd0, FREE_W'(BITS_PER_GROUP_DEF)));
        // Unused mode with every field at its maximum.
        r             = '1;
        r.mode        = MODE_UNUSED;
        send_req(r);
        // Smallest volume: only group zero lies inside the wrap point.
        drain();
        set_config(15'd1, 1'b1);
        send_req(count_req(4'd0, '0));
        send_req(alloc_req(4'd0));
        // Start past the wrap point with a live counter: allocates there.
        send_req(alloc_req(4'd9));
        send_req(count_req(4'd9, '0));
        // Start past the wrap point, everything empty: the walk gives up.
        send_req(alloc_req(4'd9));
    endtask

    // Mostly well-formed sequences with random content, some noise.
    task automatic random_phase(input int target);
        int   pick;
        int   k;
        int   i;
        logic [3:0] g;
        req_t r;
        while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            g    = 4'($urandom_range(0, 15));
            if (pick < 50) begin
                send_req(alloc_req(g));
            end else if (pick < 63) begin
                send_req(count_req(g, biased_count()));
            end else if (pick < 78) begin
                send_req(word_req(g, 5'($urandom_range(0, 31)), biased_word()));
            end else if (pick < 84) begin
                r      = rand_req();
                r.mode = MODE_UNUSED;
                send_req(r);
            end else if (pick < 87) begin
                // Fill a whole group's bitmap, keep its counter, then allocate.
                for (i = 0; i < 32; i++) send_req(word_req(g, 5'(i), 32'hFFFF_FFFF));
                send_req(alloc_req(g));
            end else if (pick < 97) begin
                // Empty a run of counters, then start a walk inside it.
                k = $urandom_range(1, 16);
                for (i = 0; i < k; i++) send_req(count_req(4'(int'(g) + i), '0));
                send_req(alloc_req(4'(int'(g) + int'($urandom_range(0, k - 1)))));
            end else begin
                // Restore a group to all free.
                for (i = 0; i < 32; i++) send_req(word_req(g, 5'(i), 32'h0));
                send_req(count_req(g, FREE_W'(BITS_PER_GROUP_DEF)));
            end
        end
    endtask

    initial begin : stimulus
        int p;
        logic [TB_W-1:0] blocks;
        logic offset;
        int sp;
        int dp;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        // Writes are taken during the clearing pass; requests wait for it.
        set_config(VOL_BLOCKS_RST, 1'b0);
        directed();
        for (p = 0; p < PHASES; p++) begin
            drain();
            case (p)
                0:       begin blocks = 15'd16384; offset = 1'b0; sp = 0;  dp = 0;  end
                1:       begin blocks = 15'd1;     offset = 1'b1; sp = 82; dp = 0;  end
                2:       begin blocks = 15'd5000;  offset = 1'b0; sp = 0;  dp = 82; end
                3:       begin blocks = 15'd32767; offset = 1'b1; sp = 10; dp = 10; end
                4:       begin blocks = 15'd0;     offset = 1'b0; sp = 82; dp = 0;  end
                5:       begin blocks = 15'd3000;  offset = 1'b1; sp = 0;  dp = 82; end
                default: begin blocks = 15'd16384; offset = 1'b1; sp = 0;  dp = 0;  end
            endcase
            set_config(blocks, offset);
            src_idle_pct = sp;
            dst_idle_pct <= dp;
            // Back up the block once while the sender keeps offering.
            if (p == 3) hold_req <= ~hold_req;
            random_phase(items_sent + PHASE_ITEMS);
        end
        drain();
        repeat (100) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
